>>> sv/ggf_pkg.sv
// Shared types and constants of the 3x3 gray Gaussian filter.
// Used by the filter core top, by ggf_div and by the checker; ggf_ram does not use it.
`default_nettype none

package ggf_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 12;
  localparam int HGT_W  = 13;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [COL_W-1:0] WIDTH_RST  = 12'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd768;

  // Register select, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // floor(x/3) == (x*683)>>11 for x below 768
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             flush;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> sv/ggf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ggf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/ggf_div.sv
// Restoring divider, one quotient bit per cycle.
// Realigns the result column/row after a width change. Uses ggf_pkg.
`default_nettype none

module ggf_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DVD_W-1:0]          dividend_i,
  input  logic [DVS_W-1:0]          divisor_i,
  output ggf_pkg::div_status_t      status_o,
  output logic [DVD_W-1:0]          quotient_o,
  output logic [DVS_W-1:0]          remainder_o
);
  import ggf_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   part, diff;
  logic             ge;

  assign part  = {rem_q, quo_q[DVD_W-1]};
  assign diff  = part - {1'b0, divisor_i};
  assign ge    = part >= {1'b0, divisor_i};
  assign rem_d = ge ? diff[DVS_W-1:0] : part[DVS_W-1:0];
  assign quo_d = {quo_q[DVD_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign status_o.busy = busy_q | done_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

>>> sv/gray_gauss3x3_filter_core.sv
// Top level of the 3x3 gray Gaussian filter: APB registers, position counters,
// line store, window and result register. Uses ggf_pkg, ggf_ram, ggf_div.
`default_nettype none

// Takes one RGB pixel per clock in raster order while in_ready_o is high and
// returns the 1-2-1 Gaussian blur of its gray image, 0 on the frame border. A
// pixel's result comes out with the item accepted width+1 items later, so feed
// width+1 flush beats after the last pixel; frame_end marks the frame's last
// result. Internally an item spends three register stages (input/line-store
// read, window, result), which advance together unless the output side stalls,
// so the sustained rate is one item per clock, limited by the output side and
// by the divider hold-off. The two previous rows live in one 16-bit wide
// MAX_WIDTH-deep RAM with one read and one write port, used once per item each.
// Writing the width register holds in_ready_o low while a one-bit-per-cycle
// divider realigns the result position. The line store is not cleared after
// reset; unwritten entries only feed border results.
module gray_gauss3x3_filter_core #(
  parameter int MAX_WIDTH = ggf_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ggf_pkg::pixel_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ggf_pkg::result_t              out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ggf_pkg::APB_AW-1:0]    paddr,
  input  logic [ggf_pkg::APB_DW-1:0]    pwdata,
  output logic [ggf_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import ggf_pkg::*;

  localparam int WREG_MAX = (1 << COL_W) - 1;
  localparam int WMAX     = (MAX_WIDTH < WREG_MAX) ? MAX_WIDTH : WREG_MAX;
  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int OI_W     = $clog2(WMAX * MAX_HEIGHT);

  localparam logic [COL_W-1:0] WMAX_V = COL_W'(WMAX);
  localparam logic [COL_W-1:0] WMIN_V = COL_W'(MIN_DIM);
  localparam logic [HGT_W-1:0] HMAX_V = HGT_W'(MAX_HEIGHT);
  localparam logic [HGT_W-1:0] HMIN_V = HGT_W'(MIN_DIM);
  localparam logic [1:0]       ROW_FULL = 2'd2;

  // ---------------- configuration ----------------
  logic [COL_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic             cfg_wr, width_wr;
  logic [COL_W-1:0] w_eff, w_m1;
  logic [HGT_W-1:0] h_eff;
  logic [OI_W-1:0]  h_ext, h_m1;

  assign cfg_wr   = psel & penable & pwrite;
  assign width_wr = cfg_wr & (paddr[2] == REG_WIDTH);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[COL_W-1:0];
        REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign w_eff = (width_q < WMIN_V) ? WMIN_V : ((width_q > WMAX_V) ? WMAX_V : width_q);
  assign h_eff = (height_q < HMIN_V) ? HMIN_V : ((height_q > HMAX_V) ? HMAX_V : height_q);
  assign w_m1  = w_eff - COL_W'(1);
  assign h_ext = OI_W'(h_eff);
  assign h_m1  = h_ext - OI_W'(1);

  // ---------------- handshake ----------------
  div_status_t div_st;
  logic        s1_valid_q, s2_valid_q, out_valid_q;
  logic        s2_emit_q, s2_inner_q, s2_last_q;
  logic        out_free, s2_free, s1_adv, accept, s2_last_leave;

  assign out_free      = !out_valid_q || out_ready_i;
  assign s2_free       = !s2_valid_q || !s2_emit_q || out_free;
  assign s1_adv        = s1_valid_q && s2_free;
  assign in_ready_o    = (!s1_valid_q || s2_free) && !div_st.busy;
  assign accept        = in_valid_i && in_ready_o;
  assign s2_last_leave = s2_valid_q && s2_emit_q && s2_last_q && out_free;

  // ---------------- position counters ----------------
  logic [COL_W-1:0] col_q, col_cur, col_inc, col_nxt;
  logic [1:0]       row_q, row_cur, row_nxt;
  logic [OI_W-1:0]  oi_q, ry_q, div_quo;
  logic [COL_W-1:0] rx_q, div_rem;
  logic             wrap0, wrap1, emit, rx_last, inner, last;

  always_comb begin
    wrap0   = col_q >= w_eff;
    col_cur = wrap0 ? '0 : col_q;
    row_cur = (wrap0 && row_q != ROW_FULL) ? row_q + 2'd1 : row_q;
    emit    = (row_cur == ROW_FULL) || (row_cur == 2'd1 && col_cur != '0);
    col_inc = col_cur + COL_W'(1);
    wrap1   = col_inc >= w_eff;
    col_nxt = wrap1 ? '0 : col_inc;
    row_nxt = (wrap1 && row_cur != ROW_FULL) ? row_cur + 2'd1 : row_cur;
    rx_last = rx_q == w_m1;
    inner   = (rx_q != '0) && !rx_last && (ry_q != '0) && (ry_q != h_m1);
    last    = (ry_q >= h_ext) || (ry_q == h_m1 && rx_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      oi_q  <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
    end else if (div_st.done) begin
      rx_q <= div_rem;
      ry_q <= div_quo;
    end else if (accept) begin
      if (emit && last) begin
        // frame done: next beat starts a new frame
        col_q <= '0;
        row_q <= '0;
        oi_q  <= '0;
        rx_q  <= '0;
        ry_q  <= '0;
      end else begin
        col_q <= col_nxt;
        row_q <= row_nxt;
        if (emit) begin
          oi_q <= oi_q + OI_W'(1);
          if (rx_last) begin
            rx_q <= '0;
            ry_q <= ry_q + OI_W'(1);
          end else begin
            rx_q <= rx_q + COL_W'(1);
          end
        end
      end
    end
  end

  ggf_div #(
    .DVD_W (OI_W),
    .DVS_W (COL_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (width_wr),
    .dividend_i  (oi_q),
    .divisor_i   (w_eff),
    .status_o    (div_st),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // ---------------- stage 1: input register, line store read ----------------
  pixel_t          s1_pix_q;
  logic [AW-1:0]   s1_col_q, raddr;
  logic            s1_emit_q, s1_inner_q, s1_last_q;
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata, rd_data, fwd_data_q;
  logic            fwd_q;
  logic [PIX_W-1:0] top_px, mid_px, gray_px;
  logic [9:0]      rgb_sum;
  logic [19:0]     gray_prod;

  assign raddr = AW'(col_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        // same entry written this edge: forward the new data
        fwd_q      <= s1_adv && (s1_col_q == raddr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= in_data_i;
      s1_col_q   <= raddr;
      s1_emit_q  <= emit;
      s1_inner_q <= inner;
      s1_last_q  <= last;
      fwd_data_q <= ram_wdata;
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : ram_rdata;
  assign top_px  = rd_data[2*PIX_W-1:PIX_W];
  assign mid_px  = rd_data[PIX_W-1:0];

  assign rgb_sum   = 10'(s1_pix_q.red) + 10'(s1_pix_q.green) + 10'(s1_pix_q.blue);
  assign gray_prod = 20'(rgb_sum + 10'd1) * 20'(RECIP3);
  assign gray_px   = s1_pix_q.flush ? '0 : gray_prod[RECIP3_SH+PIX_W-1:RECIP3_SH];

  // upper byte: row before last, lower byte: last row
  assign ram_wdata = {mid_px, gray_px};

  ggf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- stage 2: window ----------------
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_d [3][3];
  logic [PIX_W-1:0] win_b [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_b[r][c] = s2_last_leave ? '0 : win_q[r][c];
      end
    end
    win_d = win_b;
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_b[r][1];
        win_d[r][1] = win_b[r][2];
      end
      win_d[0][2] = top_px;
      win_d[1][2] = mid_px;
      win_d[2][2] = gray_px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_free) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_emit_q  <= s1_emit_q;
      s2_inner_q <= s1_inner_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // ---------------- result register ----------------
  logic [11:0]      wsum;
  logic [12:0]      wround;
  result_t          out_d, out_q;

  assign wsum = 12'(win_q[0][0])        + (12'(win_q[0][1]) << 1) + 12'(win_q[0][2])
              + (12'(win_q[1][0]) << 1) + (12'(win_q[1][1]) << 2) + (12'(win_q[1][2]) << 1)
              + 12'(win_q[2][0])        + (12'(win_q[2][1]) << 1) + 12'(win_q[2][2]);
  assign wround = 13'(wsum) + 13'd8;

  assign out_d.smoothed  = s2_inner_q ? wround[11:4] : '0;
  assign out_d.frame_end = s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_valid_q && s2_emit_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_emit_q && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sv/ggf_chk.sv
// Port-level checker for the 3x3 gray Gaussian filter core, bound to its top.
// Uses ggf_pkg.
`default_nettype none

module ggf_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire ggf_pkg::result_t           out_data_o,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [ggf_pkg::APB_AW-1:0] paddr,
  input wire logic [ggf_pkg::APB_DW-1:0] pwdata,
  input wire logic [ggf_pkg::APB_DW-1:0] prdata
);
  import ggf_pkg::*;

  logic width_wr, width_rd;

  assign width_wr = psel && penable && pwrite && (paddr[2] == REG_WIDTH);
  assign width_rd = psel && !pwrite && (paddr[2] == REG_WIDTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_width_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_wr |=> !in_ready_o)
    else $error("input taken while result position is being realigned");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_wr |=> (!width_rd || prdata[COL_W-1:0] == $past(pwdata[COL_W-1:0])))
    else $error("width register reads back wrong value");

endmodule

bind gray_gauss3x3_filter_core ggf_chk u_ggf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire

>>> bench/gray_gauss3x3_filter_core_tb.sv
// Self-checking bench for gray_gauss3x3_filter_core: RGB raster frames go in, gray blur results
// come out and are checked against a bit-exact line-store/window predictor kept in a scoreboard.
// Depends on ggf_pkg (pixel_t, result_t, register selects, size limits) and the core itself.
module gray_gauss3x3_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ggf_pkg::*;

  // Width divider hold-off plus the three item stages, with margin
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned BURST_HOLD    = 400;

  class blur_scoreboard;
    logic [COL_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    bit [PIX_W-1:0]   row_above [DEF_MAX_WIDTH];
    bit [PIX_W-1:0]   row_two_above [DEF_MAX_WIDTH];
    bit [PIX_W-1:0]   win [3][3];   // [top,mid,bot][left,center,right]
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      out_pos;
    result_t          expected_blur [$];
    int unsigned      failures;
    int unsigned      pixels_taken;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void set_register(input logic sel, input logic [APB_DW-1:0] value);
      if (sel == REG_WIDTH) width_reg = value[COL_W-1:0];
      else height_reg = value[HGT_W-1:0];
    endfunction

    function void flag(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
    endfunction

    function void clear_frame();
      foreach (win[r, c]) win[r][c] = '0;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
    endfunction

    function void step_column();
      col_pos = 0;
      if (row_pos < 32'hFFFF) row_pos++;
    endfunction

    function void note_pixel(input pixel_t px);
      int unsigned w, h, col, gray, rgb_sum, top, mid, rx, ry, sum, val;
      bit emit, last;
      result_t r;
      w = eff_width();
      h = eff_height();
      pixels_taken++;
      if (col_pos >= w) step_column();
      col = col_pos;
      gray = 0;
      if (!px.flush) begin
        rgb_sum = px.red + px.green + px.blue + 1;
        gray = rgb_sum / 3;
      end
      top = row_two_above[col];
      mid = row_above[col];
      row_two_above[col] = mid[PIX_W-1:0];
      row_above[col]     = gray[PIX_W-1:0];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top[PIX_W-1:0];
      win[1][2] = mid[PIX_W-1:0];
      win[2][2] = gray[PIX_W-1:0];
      // a result exists once the window reaches one row and one column in
      emit = (row_pos >= 2) || (row_pos == 1 && col >= 1);
      col_pos++;
      if (col_pos >= w) step_column();
      if (!emit) return;
      rx   = out_pos % w;
      ry   = out_pos / w;
      last = (out_pos + 1 >= w * h);
      val  = 0;
      if (rx != 0 && rx != w - 1 && ry != 0 && ry != h - 1) begin
        sum = win[0][0] + 2 * win[0][1] + win[0][2]
            + 2 * win[1][0] + 4 * win[1][1] + 2 * win[1][2]
            + win[2][0] + 2 * win[2][1] + win[2][2];
        val = (sum + 8) >> 4;
        if (val > 255) val = 255;
      end
      r.smoothed  = val[PIX_W-1:0];
      r.frame_end = last;
      expected_blur.push_back(r);
      if (last) clear_frame();
      else out_pos++;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_blur.size() == 0) begin
        flag($sformatf("result with nothing expected: smoothed %0d frame_end %0b",
                       got.smoothed, got.frame_end));
        return;
      end
      want = expected_blur.pop_front();
      if (got.smoothed !== want.smoothed || got.frame_end !== want.frame_end)
        flag($sformatf("smoothed exp %0d got %0d, frame_end exp %0b got %0b",
                       want.smoothed, got.smoothed, want.frame_end, got.frame_end));
    endfunction

    function int unsigned pending();
      return expected_blur.size();
    endfunction

    function bit frame_open();
      return (col_pos != 0) || (row_pos != 0) || (out_pos != 0);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  pixel_t             in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  result_t            out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  blur_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             burst_req;

  gray_gauss3x3_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL gray_gauss3x3_filter_core");
    $finish;
  end

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pixel(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (burst_req) begin
        burst_req = 1'b0;
        hold_left = BURST_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic f);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.flush = f;
    return p;
  endfunction

  function automatic pixel_t rand_pixel(input logic f);
    logic [31:0] bits;
    bits = $urandom();
    return mk_pixel(bits[7:0], bits[15:8], bits[23:16], f);
  endfunction

  // All tasks start and end just after a falling edge
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback, want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(sel, value);
    @(negedge clk_i);
    // read the register straight back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (sel == REG_WIDTH) ? (value & 32'hFFF) : (value & 32'h1FFF);
    if (readback !== want)
      sb.flag($sformatf("register %0b readback exp %0h got %0h", sel, want, readback));
  endtask

  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [APB_DW-1:0] w_reg, input logic [APB_DW-1:0] h_reg);
    wait_idle();
    write_reg(REG_WIDTH, w_reg);
    write_reg(REG_HEIGHT, h_reg);
  endtask

  // Close any frame left open by noise beats with dummy beats
  task automatic drain_frame();
    while (sb.frame_open()) send_pixel(rand_pixel(1'b1));
  endtask

  // Start a frame and stop after a few beats, leaving it open
  task automatic partial_frame(input logic [APB_DW-1:0] w_reg,
                               input logic [APB_DW-1:0] h_reg,
                               input int unsigned beats);
    set_frame(w_reg, h_reg);
    repeat (beats) send_pixel(rand_pixel(1'b0));
  endtask

  task automatic run_frames(input logic [APB_DW-1:0] w_reg, input logic [APB_DW-1:0] h_reg,
                            input int unsigned frames);
    int unsigned w, h;
    set_frame(w_reg, h_reg);
    w = sb.eff_width();
    h = sb.eff_height();
    repeat (frames) begin
      repeat (w * h) send_pixel(rand_pixel($urandom_range(99) < 3));
      // padding: mostly dummy beats, sometimes real pixels
      repeat (w + 1) send_pixel(rand_pixel($urandom_range(99) >= 10));
      // now and then spill extra beats into the next frame
      if ($urandom_range(9) == 0) repeat ($urandom_range(w, 1)) send_pixel(rand_pixel(1'b0));
    end
    drain_frame();
  endtask

  task automatic random_phase(input int unsigned beats);
    int unsigned goal;
    goal = sb.pixels_taken + beats;
    while (sb.pixels_taken < goal)
      run_frames($urandom_range(16, 3), $urandom_range(8, 3), $urandom_range(3, 1));
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_req     = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 73;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Smallest frame: full-scale pixels, then dummies carrying set color bits
    set_frame(3, 3);
    repeat (9) send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    repeat (4) send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    // Rounding corners of the gray mean, a dummy inside the frame, a pixel as padding
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pixel(8'd1, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pixel(8'd1, 8'd1, 8'd0, 1'b0));
    send_pixel(mk_pixel(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(mk_pixel(8'd0, 8'd255, 8'd0, 1'b0));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(mk_pixel(8'd128, 8'd64, 8'd32, 1'b0));
    send_pixel(mk_pixel(8'd200, 8'd100, 8'd50, 1'b1));
    send_pixel(mk_pixel(8'd255, 8'd255, 8'd254, 1'b0));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(mk_pixel(8'd17, 8'd34, 8'd51, 1'b0));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 1'b1));

    // Long result-side hold-off while a whole 8x6 frame plus padding keeps coming
    set_frame(8, 6);
    burst_req = 1'b1;
    repeat (57) send_pixel(rand_pixel(1'b0));
    random_phase(350);

    send_idle_pct = 73;
    recv_idle_pct = 18;
    random_phase(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Out-of-range sizes saturate to the limits
    run_frames(0, 0, 1);
    run_frames(2, 2, 1);
    // Oversized registers on a fresh frame, then shrink the frame part way through
    partial_frame(4095, 8191, 40);
    set_frame(5, 3);
    drain_frame();
    // Width change with results already out realigns the result position
    partial_frame(7, 30, 60);
    set_frame(4, 30);
    drain_frame();
    random_phase(350);

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS gray_gauss3x3_filter_core");
    end else begin
      $display("FAIL gray_gauss3x3_filter_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ggf_pkg.sv
sv/ggf_ram.sv
sv/ggf_div.sv
sv/gray_gauss3x3_filter_core.sv
sv/ggf_chk.sv
bench/gray_gauss3x3_filter_core_tb.sv
